// ----- sv/usa_pkg.sv -----
// Shared types, widths and register codes of the untile scatter address block.
`timescale 1ns / 1ps

package usa_pkg;

  // Bounds that the configuration registers are clamped to.
  localparam int MAX_IN_DIM = 256;
  localparam int MAX_UP     = 8;
  localparam int MAX_MAPS   = 1024;

  // Field widths of the words on the ports.
  localparam int OUT_ENTRY_W = 10;
  localparam int TILE_W      = 12;
  localparam int MAP_W       = 10;
  localparam int POS_W       = 8;
  localparam int SAMPLE_W    = 32;
  localparam int ADDR_W      = 48;

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_DIM_FW  = 9;
  localparam int CFG_MAPS_FW = 11;
  localparam int CFG_UP_FW   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X_LEVEL0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y_LEVEL0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X_LEVEL1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y_LEVEL1 = 3'd6;

  // Widths of the clamped registers and of the values derived from them.
  localparam int     DIM_W  = $clog2(MAX_IN_DIM + 1);
  localparam int     UP_W   = $clog2(MAX_UP + 1);
  localparam int     MAPS_W = $clog2(MAX_MAPS + 1);
  localparam longint MAX_T  = longint'(MAX_UP) * longint'(MAX_UP);
  localparam longint MAX_SIDE = longint'(MAX_IN_DIM) * MAX_T;
  localparam int     T_W    = $clog2(MAX_T + 1);
  localparam int     TT_W   = $clog2(MAX_T * MAX_T + 1);
  localparam int     SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int     AREA_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int     GRP_W  = $clog2(longint'(1 << OUT_ENTRY_W) * longint'(MAX_MAPS));
  localparam int     PROD_W = GRP_W + AREA_W;

  // Quotient widths of the tile digit split.
  localparam int Q1_RAW   = $clog2(MAX_T);
  localparam int Q1_W     = (Q1_RAW < 1) ? 1 : ((Q1_RAW > TILE_W) ? TILE_W : Q1_RAW);
  localparam int Q1_SPLIT = Q1_W / 2;
  localparam int QU_W     = ($clog2(MAX_UP) < 1) ? 1 : $clog2(MAX_UP);

  // Number of register stages from input to output.
  localparam int PIPE_DEPTH = 7;

  typedef struct packed {
    logic [OUT_ENTRY_W-1:0] out_entry;
    logic [TILE_W-1:0]      tile;
    logic [MAP_W-1:0]       map_index;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;
    logic [SAMPLE_W-1:0]    sample;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   out_address;
    logic [SAMPLE_W-1:0] out_sample;
    logic                bad_index;
  } out_word_t;

endpackage

// ----- sv/untile_scatter_address_core.sv -----
// Top level of the untile scatter address block: a seven-stage address pipeline.
`timescale 1ns / 1ps

// Depth-to-space scatter address generator. Each input word carries one element of a
// tiled tensor; the result word gives its address in the untiled buffer,
// ((entry*maps+map)*Wout*Hout) + (y*Ty+dy)*Wout + x*Tx + dx, with the sample passed through
// and bad_index set (address 0) when the tile, map or coordinate is out of range.
// A word is taken every cycle unless an output stall has backed up to the input.
// The pipeline has seven register stages: the input register, two for the tile split
// by the level-zero tile size, one for the per-level digit split and the large
// entry-times-area product, two for the offset products and one final add. Each stage
// holds its own valid bit, so a stall on the output fills bubbles before it stops the
// input. Register writes are taken in every cycle; the clamped values settle into the
// derived sizes over the following cycles, in step with the first word that can reach
// each stage.
module untile_scatter_address_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  usa_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output usa_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [usa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import usa_pkg::*;

  localparam int DV_W  = TILE_W + T_W;
  localparam int DV0_W = T_W + UP_W;
  localparam int DV1_W = Q1_W + UP_W;

  typedef struct packed {
    logic [GRP_W-1:0]    grp;
    logic [TILE_W-1:0]   tile;
    logic [TILE_W-1:0]   rem;
    logic [Q1_W-1:0]     q1;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } s2_t;

  typedef struct packed {
    logic [GRP_W-1:0]    grp;
    logic [T_W-1:0]      d0;
    logic [Q1_W-1:0]     d1;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } s3_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   area_term;
    logic [UP_W-1:0]     lx0;
    logic [QU_W-1:0]     ly0;
    logic [UP_W-1:0]     lx1;
    logic [QU_W-1:0]     ly1;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } s4_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   area_term;
    logic [SIDE_W-1:0]   row;
    logic [SIDE_W-1:0]   col;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } s5_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [AREA_W-1:0]   rowoff;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } s6_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_FW-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (32'(v) > MAX_IN_DIM) return DIM_W'(MAX_IN_DIM);
    else return DIM_W'(v);
  endfunction

  function automatic logic [MAPS_W-1:0] clamp_maps(input logic [CFG_MAPS_FW-1:0] v);
    if (v == '0) return MAPS_W'(1);
    else if (32'(v) > MAX_MAPS) return MAPS_W'(MAX_MAPS);
    else return MAPS_W'(v);
  endfunction

  function automatic logic [UP_W-1:0] clamp_up(input logic [CFG_UP_FW-1:0] v);
    if (v == '0) return UP_W'(1);
    else if (32'(v) > MAX_UP) return UP_W'(MAX_UP);
    else return UP_W'(v);
  endfunction

  // Clamped configuration registers.
  logic [DIM_W-1:0]  wid_r, hgt_r;
  logic [MAPS_W-1:0] maps_r;
  logic [UP_W-1:0]   ux0_r, uy0_r, ux1_r, uy1_r;

  // Derived sizes, one product level per register.
  logic [T_W-1:0]    t0_r, t1_r, tx_r, ty_r;
  logic [TT_W-1:0]   tt_r;
  logic [SIDE_W-1:0] wout_r, hout_r;
  logic [AREA_W-1:0] area_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] adv;

  in_word_t  s1_r;
  s2_t       s2_r, s2_nxt;
  s3_t       s3_r, s3_nxt;
  s4_t       s4_r, s4_nxt;
  s5_t       s5_r, s5_nxt;
  s6_t       s6_r, s6_nxt;
  out_word_t out_r, out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r  <= DIM_W'(1);
      hgt_r  <= DIM_W'(1);
      maps_r <= MAPS_W'(1);
      ux0_r  <= UP_W'(1);
      uy0_r  <= UP_W'(1);
      ux1_r  <= UP_W'(1);
      uy1_r  <= UP_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IN_WIDTH:    wid_r  <= clamp_dim(cfg_data[CFG_DIM_FW-1:0]);
        CFG_IN_HEIGHT:   hgt_r  <= clamp_dim(cfg_data[CFG_DIM_FW-1:0]);
        CFG_MAP_COUNT:   maps_r <= clamp_maps(cfg_data[CFG_MAPS_FW-1:0]);
        CFG_UP_X_LEVEL0: ux0_r  <= clamp_up(cfg_data[CFG_UP_FW-1:0]);
        CFG_UP_Y_LEVEL0: uy0_r  <= clamp_up(cfg_data[CFG_UP_FW-1:0]);
        CFG_UP_X_LEVEL1: ux1_r  <= clamp_up(cfg_data[CFG_UP_FW-1:0]);
        CFG_UP_Y_LEVEL1: uy1_r  <= clamp_up(cfg_data[CFG_UP_FW-1:0]);
        default: begin
        end
      endcase
    end
  end

  // The first level feeds stage two, the second stage three and the area stage four, so a
  // word that follows a register write never sees a stale size.
  always_ff @(posedge clk) begin
    t0_r   <= T_W'(T_W'(ux0_r) * T_W'(uy0_r));
    t1_r   <= T_W'(T_W'(ux1_r) * T_W'(uy1_r));
    tx_r   <= T_W'(T_W'(ux0_r) * T_W'(ux1_r));
    ty_r   <= T_W'(T_W'(uy0_r) * T_W'(uy1_r));
    tt_r   <= TT_W'(TT_W'(t0_r) * TT_W'(t1_r));
    wout_r <= SIDE_W'(SIDE_W'(wid_r) * SIDE_W'(tx_r));
    hout_r <= SIDE_W'(SIDE_W'(hgt_r) * SIDE_W'(ty_r));
    area_r <= AREA_W'(AREA_W'(wout_r) * AREA_W'(hout_r));
  end

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage two: map and coordinate range checks, entry-map group and upper quotient bits of tile / t0.
  always_comb begin
    logic [DV_W-1:0] rem;
    logic [Q1_W-1:0] q;
    rem = DV_W'(s1_r.tile);
    q   = '0;
    for (int k = Q1_W - 1; k >= Q1_SPLIT; k--) begin
      if (rem >= (DV_W'(t0_r) << k)) begin
        rem  = rem - (DV_W'(t0_r) << k);
        q[k] = 1'b1;
      end
    end
    s2_nxt.grp    = GRP_W'(GRP_W'(s1_r.out_entry) * GRP_W'(maps_r))
                    + GRP_W'(s1_r.map_index);
    s2_nxt.tile   = s1_r.tile;
    s2_nxt.rem    = TILE_W'(rem);
    s2_nxt.q1     = q;
    s2_nxt.px     = s1_r.pos_x;
    s2_nxt.py     = s1_r.pos_y;
    s2_nxt.sample = s1_r.sample;
    s2_nxt.bad    = (32'(s1_r.map_index) >= 32'(maps_r)) ||
                    (32'(s1_r.pos_x) >= 32'(wid_r)) ||
                    (32'(s1_r.pos_y) >= 32'(hgt_r));
  end

  // Stage three: lower quotient bits and the tile range check; what is left is the level-zero digit.
  always_comb begin
    logic [DV_W-1:0] rem;
    logic [Q1_W-1:0] q;
    rem = DV_W'(s2_r.rem);
    q   = s2_r.q1;
    for (int k = Q1_SPLIT - 1; k >= 0; k--) begin
      if (rem >= (DV_W'(t0_r) << k)) begin
        rem  = rem - (DV_W'(t0_r) << k);
        q[k] = 1'b1;
      end
    end
    s3_nxt.grp    = s2_r.grp;
    s3_nxt.d0     = T_W'(rem);
    s3_nxt.d1     = q;
    s3_nxt.px     = s2_r.px;
    s3_nxt.py     = s2_r.py;
    s3_nxt.sample = s2_r.sample;
    s3_nxt.bad    = s2_r.bad || (32'(s2_r.tile) >= 32'(tt_r));
  end

  // Stage four: split each level digit into x and y, and scale the group by the map area.
  always_comb begin
    logic [DV0_W-1:0]  r0;
    logic [DV1_W-1:0]  r1;
    logic [QU_W-1:0]   q0, q1;
    logic [PROD_W-1:0] prod;
    r0 = DV0_W'(s3_r.d0);
    r1 = DV1_W'(s3_r.d1);
    q0 = '0;
    q1 = '0;
    for (int k = QU_W - 1; k >= 0; k--) begin
      if (r0 >= (DV0_W'(ux0_r) << k)) begin
        r0    = r0 - (DV0_W'(ux0_r) << k);
        q0[k] = 1'b1;
      end
      if (r1 >= (DV1_W'(ux1_r) << k)) begin
        r1    = r1 - (DV1_W'(ux1_r) << k);
        q1[k] = 1'b1;
      end
    end
    prod = PROD_W'(s3_r.grp) * PROD_W'(area_r);
    s4_nxt.area_term = ADDR_W'(prod);
    s4_nxt.lx0       = UP_W'(r0);
    s4_nxt.ly0       = q0;
    s4_nxt.lx1       = UP_W'(r1);
    s4_nxt.ly1       = q1;
    s4_nxt.px        = s3_r.px;
    s4_nxt.py        = s3_r.py;
    s4_nxt.sample    = s3_r.sample;
    s4_nxt.bad       = s3_r.bad;
  end

  // Stage five: position within the untiled map.
  always_comb begin
    s5_nxt.area_term = s4_r.area_term;
    s5_nxt.col = SIDE_W'(s4_r.px) * SIDE_W'(tx_r)
               + SIDE_W'(s4_r.lx0) * SIDE_W'(ux1_r) + SIDE_W'(s4_r.lx1);
    s5_nxt.row = SIDE_W'(s4_r.py) * SIDE_W'(ty_r)
               + SIDE_W'(s4_r.ly0) * SIDE_W'(uy1_r) + SIDE_W'(s4_r.ly1);
    s5_nxt.sample = s4_r.sample;
    s5_nxt.bad    = s4_r.bad;
  end

  // Stage six: row offset and the partial sum.
  always_comb begin
    s6_nxt.rowoff = AREA_W'(s5_r.row) * AREA_W'(wout_r);
    s6_nxt.base   = s5_r.area_term + ADDR_W'(s5_r.col);
    s6_nxt.sample = s5_r.sample;
    s6_nxt.bad    = s5_r.bad;
  end

  // Output stage: the final add, forced to zero for an out-of-range word.
  always_comb begin
    out_nxt.out_address = s6_r.bad ? '0 : (s6_r.base + ADDR_W'(s6_r.rowoff));
    out_nxt.out_sample  = s6_r.sample;
    out_nxt.bad_index   = s6_r.bad;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1_r  <= in_data;
    if (adv[1]) s2_r  <= s2_nxt;
    if (adv[2]) s3_r  <= s3_nxt;
    if (adv[3]) s4_r  <= s4_nxt;
    if (adv[4]) s5_r  <= s5_nxt;
    if (adv[5]) s6_r  <= s6_nxt;
    if (adv[6]) out_r <= out_nxt;
  end

endmodule

// ----- sv/usa_checker.sv -----
// Port-level checker of the untile scatter address block and its bind to the top level.
`timescale 1ns / 1ps

module usa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input usa_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input usa_pkg::out_word_t out_data
);
  import usa_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cnt_nxt  = cnt_r + CNT_W'(in_fire) - CNT_W'(out_fire);

  // Words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_no_phantom_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result word shown with nothing in flight");

  a_empty_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cnt_r == '0 |-> ##(PIPE_DEPTH) out_valid &&
      out_data.out_sample == $past(in_data.sample, PIPE_DEPTH))
    else $error("word through an empty pipeline late or sample altered");

  a_bad_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_index |-> out_data.out_address == '0)
    else $error("out-of-range word carries a nonzero address");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

endmodule

bind untile_scatter_address_core usa_checker u_usa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/untile_scatter_address_core_tb.sv -----
// Self-checking testbench of the untile scatter address core.
`timescale 1ns / 1ps

module untile_scatter_address_core_tb;
  import usa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int GAP_PCT_SET[4]   = '{0, 46, 0, 14};
  localparam int STALL_PCT_SET[4] = '{0, 0, 46, 14};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Copies of the configuration registers as last written.
  logic [CFG_DIM_FW-1:0]  shadow_in_width = 1;
  logic [CFG_DIM_FW-1:0]  shadow_in_height = 1;
  logic [CFG_MAPS_FW-1:0] shadow_map_count = 1;
  logic [CFG_UP_FW-1:0]   shadow_up_x0 = 1;
  logic [CFG_UP_FW-1:0]   shadow_up_y0 = 1;
  logic [CFG_UP_FW-1:0]   shadow_up_x1 = 1;
  logic [CFG_UP_FW-1:0]   shadow_up_y1 = 1;

  out_word_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  untile_scatter_address_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic longint unsigned clamp_reg(input longint unsigned v,
                                                input longint unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned tile_count();
    return clamp_reg(64'(shadow_up_x0), 64'(MAX_UP)) *
           clamp_reg(64'(shadow_up_y0), 64'(MAX_UP)) *
           clamp_reg(64'(shadow_up_x1), 64'(MAX_UP)) *
           clamp_reg(64'(shadow_up_y1), 64'(MAX_UP));
  endfunction

  // Untiled address of one element under the current register settings.
  function automatic out_word_t scatter_address(input in_word_t w);
    longint unsigned wd, ht, maps, ux0, uy0, ux1, uy1, t0, tx, ty, wout, hout;
    longint unsigned entry, tile, map, px, py, d0, d1, dx, dy, addr;
    out_word_t r;
    wd   = clamp_reg(64'(shadow_in_width), 64'(MAX_IN_DIM));
    ht   = clamp_reg(64'(shadow_in_height), 64'(MAX_IN_DIM));
    maps = clamp_reg(64'(shadow_map_count), 64'(MAX_MAPS));
    ux0  = clamp_reg(64'(shadow_up_x0), 64'(MAX_UP));
    uy0  = clamp_reg(64'(shadow_up_y0), 64'(MAX_UP));
    ux1  = clamp_reg(64'(shadow_up_x1), 64'(MAX_UP));
    uy1  = clamp_reg(64'(shadow_up_y1), 64'(MAX_UP));
    entry = 64'(w.out_entry);
    tile  = 64'(w.tile);
    map   = 64'(w.map_index);
    px    = 64'(w.pos_x);
    py    = 64'(w.pos_y);
    t0   = ux0 * uy0;
    tx   = ux0 * ux1;
    ty   = uy0 * uy1;
    wout = wd * tx;
    hout = ht * ty;
    r.out_sample  = w.sample;
    r.bad_index   = (tile >= t0 * ux1 * uy1) || (map >= maps) || (px >= wd) || (py >= ht);
    r.out_address = '0;
    if (!r.bad_index) begin
      // Level zero is the low digit of the tile index; x runs fastest in each level.
      d0 = tile % t0;
      d1 = tile / t0;
      dx = (d0 % ux0) * ux1 + d1 % ux1;
      dy = (d0 / ux0) * uy1 + d1 / ux1;
      addr = (entry * maps + map) * wout * hout + (py * ty + dy) * wout + px * tx + dx;
      r.out_address = addr[ADDR_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 64'(out_data.out_address), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_address !== want.out_address)
          report_mismatch("out_address", 64'(out_data.out_address),
                          64'(want.out_address));
        if (out_data.out_sample !== want.out_sample)
          report_mismatch("out_sample", 64'(out_data.out_sample), 64'(want.out_sample));
        if (out_data.bad_index !== want.bad_index)
          report_mismatch("bad_index", 64'(out_data.bad_index), 64'(want.bad_index));
      end
    end
  end

  // Returns in the time step of the edge that accepted the word.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), scatter_address(w));
  endtask

  function automatic in_word_t make_word(input int entry, input int tile, input int map,
                                         input int px, input int py,
                                         input logic [SAMPLE_W-1:0] sample);
    in_word_t w;
    w.out_entry = OUT_ENTRY_W'(entry);
    w.tile      = TILE_W'(tile);
    w.map_index = MAP_W'(map);
    w.pos_x     = POS_W'(px);
    w.pos_y     = POS_W'(py);
    w.sample    = sample;
    return w;
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IN_WIDTH:    shadow_in_width  = data[CFG_DIM_FW-1:0];
      CFG_IN_HEIGHT:   shadow_in_height = data[CFG_DIM_FW-1:0];
      CFG_MAP_COUNT:   shadow_map_count = data[CFG_MAPS_FW-1:0];
      CFG_UP_X_LEVEL0: shadow_up_x0     = data[CFG_UP_FW-1:0];
      CFG_UP_Y_LEVEL0: shadow_up_y0     = data[CFG_UP_FW-1:0];
      CFG_UP_X_LEVEL1: shadow_up_x1     = data[CFG_UP_FW-1:0];
      CFG_UP_Y_LEVEL1: shadow_up_y1     = data[CFG_UP_FW-1:0];
      default: ;
    endcase
  endtask

  // Registers change only once every word in flight has come out.
  task automatic write_config(input logic [CFG_DATA_W-1:0] w, h, maps, ux0, uy0, ux1, uy1,
                              input bit poke_unused);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(CFG_IN_WIDTH, w);
    write_reg(CFG_IN_HEIGHT, h);
    write_reg(CFG_MAP_COUNT, maps);
    write_reg(CFG_UP_X_LEVEL0, ux0);
    write_reg(CFG_UP_Y_LEVEL0, uy0);
    write_reg(CFG_UP_X_LEVEL1, ux1);
    write_reg(CFG_UP_Y_LEVEL1, uy1);
    if (poke_unused)
      write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal values, with zero and all-ones fields for the clamping logic.
  // Bits above the register's field are random and must be dropped.
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int field_w,
                                                           input int bound);
    logic [CFG_DATA_W-1:0] v, chosen;
    case ($urandom_range(0, 9))
      0:       chosen = '0;
      1:       chosen = CFG_DATA_W'((1 << field_w) - 1);
      2:       chosen = CFG_DATA_W'(bound);
      default: chosen = CFG_DATA_W'($urandom_range(1, bound));
    endcase
    v = CFG_DATA_W'($urandom);
    v = (v >> field_w) << field_w;
    return v | chosen;
  endfunction

  task automatic send_random_word();
    in_word_t w;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    // Most words are in range so the address arithmetic gets exercised.
    if ($urandom_range(0, 99) < 85) begin
      w.tile      = TILE_W'($urandom_range(0, 32'(tile_count() - 1)));
      w.map_index = MAP_W'($urandom_range(0,
                      32'(clamp_reg(64'(shadow_map_count), 64'(MAX_MAPS)) - 1)));
      w.pos_x     = POS_W'($urandom_range(0,
                      32'(clamp_reg(64'(shadow_in_width), 64'(MAX_IN_DIM)) - 1)));
      w.pos_y     = POS_W'($urandom_range(0,
                      32'(clamp_reg(64'(shadow_in_height), 64'(MAX_IN_DIM)) - 1)));
    end
    send_word(w);
  endtask

  // All registers at 1 after reset: only tile, map and coordinate 0 are in range.
  task automatic test_reset_defaults();
    send_word(make_word(0, 0, 0, 0, 0, 32'h0000_0000));
    send_word(make_word(1023, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(make_word(3, 1, 0, 0, 0, 32'h1234_5678));
    send_word(make_word(3, 0, 1, 0, 0, 32'h8765_4321));
    send_word(make_word(3, 0, 0, 255, 0, 32'h0F0F_0F0F));
    send_word(make_word(3, 0, 0, 0, 255, 32'hF0F0_F0F0));
  endtask

  // Largest sizes: the all-ones word lands on the last address of the buffer.
  task automatic test_largest_config();
    write_config(CFG_DATA_W'(MAX_IN_DIM), CFG_DATA_W'(MAX_IN_DIM), CFG_DATA_W'(MAX_MAPS),
                 CFG_DATA_W'(MAX_UP), CFG_DATA_W'(MAX_UP), CFG_DATA_W'(MAX_UP),
                 CFG_DATA_W'(MAX_UP), 1'b0);
    send_word(make_word(0, 0, 0, 0, 0, 32'h0000_0000));
    send_word(make_word(1023, 4095, 1023, 255, 255, 32'hFFFF_FFFF));
    send_word(make_word(0, 4095, 0, 0, 0, 32'hA5A5_A5A5));
    send_word(make_word(682, 2730, 341, 170, 85, 32'h5A5A_5A5A));
  endtask

  // A zero register acts as 1 and an oversized one as its bound.
  task automatic test_clamped_registers();
    write_config(0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_word(make_word(5, 0, 0, 0, 0, 32'hDEAD_BEEF));
    send_word(make_word(5, 1, 0, 0, 0, 32'hCAFE_F00D));
    write_config(11'h1FF, 11'h1FF, 11'h7FF, 11'hF, 11'hF, 11'hF, 11'hF, 1'b0);
    send_word(make_word(1023, 4095, 1023, 255, 255, 32'h0000_0001));
  endtask

  // Unequal factors in each level, walking the tile digits; a write to the
  // unused register index must leave the settings alone.
  task automatic test_mixed_factors();
    write_config(10, 6, 3, 2, 3, 4, 1, 1'b1);
    send_word(make_word(1, 0, 2, 9, 5, 32'h1111_1111));
    send_word(make_word(1, 1, 2, 9, 5, 32'h2222_2222));
    send_word(make_word(1, 2, 2, 9, 5, 32'h3333_3333));
    send_word(make_word(1, 5, 2, 9, 5, 32'h4444_4444));
    send_word(make_word(1, 6, 2, 9, 5, 32'h5555_5555));
    send_word(make_word(1, 23, 2, 9, 5, 32'h6666_6666));
    send_word(make_word(1, 24, 0, 0, 0, 32'h7777_7777));
    send_word(make_word(1, 0, 3, 0, 0, 32'h8888_8888));
    send_word(make_word(1, 0, 0, 10, 0, 32'h9999_9999));
    send_word(make_word(1, 0, 0, 0, 6, 32'hAAAA_AAAA));
  endtask

  task automatic test_random_traffic();
    for (int m = 0; m < 4; m++) begin
      gap_pct = GAP_PCT_SET[m];
      stall_pct = STALL_PCT_SET[m];
      for (int c = 0; c < 4; c++) begin
        write_config(pick_reg_value(CFG_DIM_FW, MAX_IN_DIM),
                     pick_reg_value(CFG_DIM_FW, MAX_IN_DIM),
                     pick_reg_value(CFG_MAPS_FW, MAX_MAPS),
                     pick_reg_value(CFG_UP_FW, MAX_UP),
                     pick_reg_value(CFG_UP_FW, MAX_UP),
                     pick_reg_value(CFG_UP_FW, MAX_UP),
                     pick_reg_value(CFG_UP_FW, MAX_UP),
                     $urandom_range(0, 3) == 0);
        repeat (72) send_random_word();
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_largest_config();
    test_clamped_registers();
    test_mixed_factors();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let any stray word behind the last one show up.
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
